/* rtl/generation_checked_handle_table_core_assert.svh */
// Assertion helpers for the handle table core.
`ifndef GENERATION_CHECKED_HANDLE_TABLE_CORE_ASSERT_SVH
`define GENERATION_CHECKED_HANDLE_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define GHTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("handle table check failed");

// Next-cycle implication, disabled while reset is low.
`define GHTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("handle table check failed");

`endif

/* rtl/ghtc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ghtc_pkg;

    localparam int REF_W  = 24;
    localparam int TAG_W  = 32;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;

    localparam int SLOTS_DEF   = 256;
    localparam int ID_BITS_DEF = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_REGISTER   = 2'd0,
        REQ_UNREGISTER = 2'd1,
        REQ_RESOLVE    = 2'd2
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_STALE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [REF_W-1:0] ref_in;
        logic [TAG_W-1:0] object_tag;
    } t_req_beat;

endpackage

`default_nettype wire

/* rtl/ghtc_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ghtc_req_if import ghtc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [REF_W-1:0] ref_in;
    logic [TAG_W-1:0] object_tag;

    modport source (output valid, output req_type, output ref_in, output object_tag,
                    input ready);
    modport sink   (input valid, input req_type, input ref_in, input object_tag,
                    output ready);
endinterface

`default_nettype wire

/* rtl/ghtc_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ghtc_rsp_if import ghtc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [REF_W-1:0]  ref_out;
    logic [TAG_W-1:0]  tag_out;

    modport source (output valid, output status, output ref_out, output tag_out,
                    input ready);
    modport sink   (input valid, input status, input ref_out, input tag_out,
                    output ready);
endinterface

`default_nettype wire

/* rtl/generation_checked_handle_table_core.sv */
// Generation-checked handle table.
// Request channel i_req (valid/ready): req_type, ref_in, object_tag. Register
// stores object_tag in the lowest free slot and returns a reference built from
// the slot index above the current id; unregister and resolve check ref_in
// against the slot's used bit and stored id and return the tag.
// Response channel o_rsp (valid/ready): status, ref_out, tag_out, one beat per
// request, in request order.
// Execution: a taken request is latched and runs in the execute state, which
// holds while the output register is full; the response register loads at
// the end of the cycle in which the request leaves execute.
// Pacing: no new request is taken until the previous one has executed, as
// the slot memory is read on the accept edge and written back in execute,
// and the registered free-slot encoder must see the updated used bits first.
// Reset (synchronous, active low) empties the table by clearing the used bits
// (flip-flops) and sets the id to 1; no clearing pass runs.
// Backpressure: a request may be taken while the previous response waits in
// the output register; a finished request then holds in execute until that
// register frees, and i_req.ready stays low meanwhile.
`timescale 1ns / 1ps
`default_nettype none

`include "generation_checked_handle_table_core_assert.svh"

module generation_checked_handle_table_core import ghtc_pkg::*; #(
    parameter int SLOTS   = SLOTS_DEF,
    parameter int ID_BITS = ID_BITS_DEF
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    ghtc_req_if.sink  i_req,
    ghtc_rsp_if.source o_rsp
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int EXT_W = REF_W + ID_BITS;
    localparam int OUT_W = IDX_W + ID_BITS + REF_W;
    localparam int ENT_W = ID_BITS + TAG_W;

    // control
    t_state             r_state, n_state;
    t_req_beat          r_req;
    logic [SLOTS-1:0]   r_used;
    logic [ID_BITS-1:0] r_next_id, n_next_id;

    // response register
    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_status, n_status;
    logic [REF_W-1:0]  r_ref_out, n_ref_out;
    logic [TAG_W-1:0]  r_tag_out, n_tag_out;

    logic w_in_acc;
    logic w_out_free;

    // address decode of the incoming reference (for the memory read)
    logic [EXT_W-1:0] w_in_ext;
    logic [REF_W-1:0] w_in_idx;

    // decode of the latched reference
    logic [EXT_W-1:0]   w_ref_ext;
    logic [REF_W-1:0]   w_ref_idx;
    logic [ID_BITS-1:0] w_ref_id;
    logic [IDX_W-1:0]   w_ref_slot;
    logic               w_live;

    // slot memory
    logic [ENT_W-1:0]   w_rd_data;
    logic [ID_BITS-1:0] w_rd_id;
    logic [TAG_W-1:0]   w_rd_tag;
    logic               w_wr_en;

    // free slot
    logic             w_full;
    logic [IDX_W-1:0] w_free_idx;
    logic [OUT_W-1:0] w_new_ref;

    // used-bit updates
    logic w_set_en, w_clr_en;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_in_acc    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    assign w_in_ext = {{ID_BITS{1'b0}}, i_req.ref_in};
    assign w_in_idx = REF_W'(w_in_ext >> ID_BITS);

    assign w_ref_ext  = {{ID_BITS{1'b0}}, r_req.ref_in};
    assign w_ref_idx  = REF_W'(w_ref_ext >> ID_BITS);
    assign w_ref_id   = w_ref_ext[ID_BITS-1:0];
    assign w_ref_slot = w_ref_idx[IDX_W-1:0];

    assign w_rd_id  = w_rd_data[ENT_W-1:TAG_W];
    assign w_rd_tag = w_rd_data[TAG_W-1:0];

    // live: nonzero, in range, slot used, id matches
    assign w_live = (r_req.ref_in != '0) && (w_ref_idx < REF_W'(SLOTS))
                    && r_used[w_ref_slot] && (w_rd_id == w_ref_id);

    assign w_new_ref = (OUT_W'(w_free_idx) << ID_BITS) | OUT_W'(r_next_id);

    ghtc_slot_ram #(
        .DEPTH  (SLOTS),
        .DATA_W (ENT_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (w_in_idx[IDX_W-1:0]),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_free_idx),
        .i_wr_data ({r_next_id, r_req.object_tag})
    );

    ghtc_free_enc #(
        .SLOTS (SLOTS)
    ) u_free (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_used  (r_used),
        .o_full  (w_full),
        .o_idx   (w_free_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_id   <= ID_BITS'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_id   <= n_next_id;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req <= '{req_type: i_req.req_type, ref_in: i_req.ref_in,
                       object_tag: i_req.object_tag};
        end
        r_status  <= n_status;
        r_ref_out <= n_ref_out;
        r_tag_out <= n_tag_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            if (w_set_en) begin
                r_used[w_free_idx] <= 1'b1;
            end
            if (w_clr_en) begin
                r_used[w_ref_slot] <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_next_id   = r_next_id;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_status    = r_status;
        n_ref_out   = r_ref_out;
        n_tag_out   = r_tag_out;
        w_wr_en     = 1'b0;
        w_set_en    = 1'b0;
        w_clr_en    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = ST_STALE;
                    n_ref_out   = '0;
                    n_tag_out   = '0;
                    case (t_req'(r_req.req_type))
                        REQ_REGISTER: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status  = ST_OK;
                                n_ref_out = w_new_ref[REF_W-1:0];
                                w_wr_en   = 1'b1;
                                w_set_en  = 1'b1;
                                // id wraps from all ones back to 1, never zero
                                n_next_id = (&r_next_id) ? ID_BITS'(1)
                                                         : r_next_id + ID_BITS'(1);
                            end
                        end
                        REQ_UNREGISTER: begin
                            if (w_live) begin
                                n_status  = ST_OK;
                                n_tag_out = w_rd_tag;
                                w_clr_en  = 1'b1;
                            end
                        end
                        REQ_RESOLVE: begin
                            if (w_live) begin
                                n_status  = ST_OK;
                                n_tag_out = w_rd_tag;
                            end
                        end
                        default: begin
                            // unused request code: stale, nothing changes
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.status  = r_status;
    assign o_rsp.ref_out = r_ref_out;
    assign o_rsp.tag_out = r_tag_out;

    // id is never zero
    `GHTC_ASSERT_NOW(a_id_nonzero, i_clk, i_rst_n, 1'b1, r_next_id != '0)
    // error beats carry no reference and no tag
    `GHTC_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, o_rsp.valid && (o_rsp.status != ST_OK), (o_rsp.ref_out == '0) && (o_rsp.tag_out == '0))
    // a taken request moves straight into execute
    `GHTC_ASSERT_NEXT(a_acc_exec, i_clk, i_rst_n, w_in_acc, r_state == S_EXEC)
    // a granted slot is marked used on the next cycle
    `GHTC_ASSERT_NEXT(a_set_used, i_clk, i_rst_n, w_set_en, r_used[$past(w_free_idx)])

endmodule

`default_nettype wire

/* rtl/ghtc_slot_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module ghtc_slot_ram import ghtc_pkg::*; #(
    parameter int DEPTH  = SLOTS_DEF,
    parameter int DATA_W = ID_BITS_DEF + TAG_W
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output      logic [DATA_W-1:0]        o_rd_data,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0]        i_wr_data
);

    logic [DATA_W-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/ghtc_free_enc.sv */
`timescale 1ns / 1ps
`default_nettype none

// Lowest-free-slot finder: binary reduction tree, result registered.
module ghtc_free_enc import ghtc_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [SLOTS-1:0]         i_used,
    output      logic                     o_full,
    output      logic [$clog2(SLOTS)-1:0] o_idx
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int P     = 1 << IDX_W;

    logic [P-1:0]     w_used_pad;
    logic             lv_found [0:IDX_W][0:P-1];
    logic [IDX_W-1:0] lv_idx   [0:IDX_W][0:P-1];

    // slots past the end count as used
    assign w_used_pad = P'(i_used) | ~(P'({SLOTS{1'b1}}));

    always_comb begin
        for (int j = 0; j < P; j++) begin
            lv_found[0][j] = ~w_used_pad[j];
            lv_idx[0][j]   = IDX_W'(j);
        end
        for (int l = 0; l < IDX_W; l++) begin
            for (int j = 0; j < P; j++) begin
                if (j < (P >> (l + 1))) begin
                    lv_found[l+1][j] = lv_found[l][2*j] | lv_found[l][2*j+1];
                    lv_idx[l+1][j]   = lv_found[l][2*j] ? lv_idx[l][2*j] : lv_idx[l][2*j+1];
                end else begin
                    lv_found[l+1][j] = 1'b0;
                    lv_idx[l+1][j]   = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_full <= 1'b0;
            o_idx  <= '0;
        end else begin
            o_full <= ~lv_found[IDX_W][0];
            o_idx  <= lv_idx[IDX_W][0];
        end
    end

endmodule

`default_nettype wire
